// ----- design/tnef_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnef_pkg
// shared codes, types and widths of the attribute stream parser
// ---------------------------------------------------------------------------
package tnef_pkg;

    localparam int DATA_W   = 152;
    localparam int CIDX_W   = 8;
    localparam int CDATA_W  = 32;

    // parser phases
    localparam logic [2:0] PH_SIG      = 3'd0;
    localparam logic [2:0] PH_KEY      = 3'd1;
    localparam logic [2:0] PH_LEVEL    = 3'd2;
    localparam logic [2:0] PH_TYPENAME = 3'd3;
    localparam logic [2:0] PH_LENGTH   = 3'd4;
    localparam logic [2:0] PH_DATA     = 3'd5;
    localparam logic [2:0] PH_CHECK    = 3'd6;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISMATCH  = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_CLEAN_END = 3'd3;
    localparam logic [2:0] ST_EARLY_END = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SIGNATURE  = 8'd0;
    localparam logic [CIDX_W-1:0] CFG_ATT_LEVEL  = 8'd1;
    localparam logic [CIDX_W-1:0] CFG_RENDER_NAME = 8'd2;

    localparam logic [31:0] SIGNATURE_RST   = 32'h223E_9F78;
    localparam logic [7:0]  ATT_LEVEL_RST   = 8'd2;
    localparam logic [15:0] RENDER_NAME_RST = 16'h9002;

    typedef struct packed {
        logic [31:0] expected_signature;
        logic [7:0]  attachment_level;
        logic [15:0] render_data_name;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  record_level;
        logic [15:0] record_type;
        logic [15:0] record_name;
        logic [31:0] record_length;
        logic [31:0] data_offset;
        logic [15:0] computed_sum;
        logic [15:0] header_key;
        logic [15:0] render_count;
    } result_t;

    typedef struct packed {
        logic       halted;
        logic [2:0] phase;
    } core_stat_t;

endpackage

// ----- design/tnef_parse_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnef_parse_core
// per-byte parser state and the result that each accepted byte causes
// ---------------------------------------------------------------------------
module tnef_parse_core
    import tnef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       res_valid,
    output result_t    res,
    output core_stat_t stat
);

    logic [2:0]  phase_reg,   phase_next;
    logic [1:0]  idx_reg,     idx_next;
    logic [31:0] asm_reg,     asm_next;
    logic [7:0]  level_reg,   level_next;
    logic [31:0] tn_reg,      tn_next;
    logic [31:0] length_reg,  length_next;
    logic [31:0] remain_reg,  remain_next;
    logic [15:0] sum_reg,     sum_next;
    logic [31:0] offset_reg,  offset_next;
    logic [31:0] start_reg,   start_next;
    logic [15:0] key_reg,     key_next;
    logic [15:0] render_reg,  render_next;
    logic        halted_reg,  halted_next;

    logic [31:0] word;
    logic        ok;

    assign word = asm_reg | ({24'd0, data_byte} << {idx_reg, 3'b000});
    assign ok   = (word[15:0] == sum_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        asm_next    = asm_reg;
        level_next  = level_reg;
        tn_next     = tn_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        sum_next    = sum_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        key_next    = key_reg;
        render_next = render_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.header_key   = key_reg;
        res.render_count = render_reg;

        if (accept && !halted_reg)
        begin
            if (end_of_stream)
            begin
                res_valid   = 1'b1;
                res.status  = (phase_reg == PH_LEVEL) ? ST_CLEAN_END : ST_EARLY_END;
                halted_next = 1'b1;
            end
            else
            begin
                if (offset_reg != 32'hFFFF_FFFF)
                    offset_next = offset_reg + 32'd1;
                idx_next = idx_reg + 2'd1;
                asm_next = word;
                case (phase_reg)
                    PH_SIG:
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            idx_next = 2'd0;
                            asm_next = 32'd0;
                            if (word != cfg.expected_signature)
                            begin
                                res_valid   = 1'b1;
                                res.status  = ST_BAD_SIG;
                                halted_next = 1'b1;
                            end
                            else
                                phase_next = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        if (idx_reg == 2'd1)
                        begin
                            key_next   = word[15:0];
                            phase_next = PH_LEVEL;
                            idx_next   = 2'd0;
                            asm_next   = 32'd0;
                        end
                    end
                    PH_LEVEL:
                    begin
                        level_next = data_byte;
                        phase_next = PH_TYPENAME;
                        idx_next   = 2'd0;
                        asm_next   = 32'd0;
                    end
                    PH_TYPENAME:
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            tn_next    = word;
                            phase_next = PH_LENGTH;
                            idx_next   = 2'd0;
                            asm_next   = 32'd0;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            length_next = word;
                            remain_next = word;
                            sum_next    = 16'd0;
                            start_next  = offset_next;
                            phase_next  = (word != 32'd0) ? PH_DATA : PH_CHECK;
                            idx_next    = 2'd0;
                            asm_next    = 32'd0;
                        end
                    end
                    PH_DATA:
                    begin
                        idx_next    = idx_reg;
                        asm_next    = asm_reg;
                        sum_next    = sum_reg + {8'd0, data_byte};
                        remain_next = remain_reg - 32'd1;
                        if (remain_reg == 32'd1)
                        begin
                            phase_next = PH_CHECK;
                            idx_next   = 2'd0;
                            asm_next   = 32'd0;
                        end
                    end
                    default:
                    begin
                        if (idx_reg == 2'd1)
                        begin
                            if (ok && level_reg == cfg.attachment_level &&
                                tn_reg[15:0] == cfg.render_data_name &&
                                render_reg != 16'hFFFF)
                                render_next = render_reg + 16'd1;
                            res_valid         = 1'b1;
                            res.status        = ok ? ST_OK : ST_MISMATCH;
                            res.record_level  = level_reg;
                            res.record_type   = tn_reg[31:16];
                            res.record_name   = tn_reg[15:0];
                            res.record_length = length_reg;
                            res.data_offset   = start_reg;
                            res.computed_sum  = sum_reg;
                            res.render_count  = render_next;
                            halted_next       = !ok;
                            phase_next        = PH_LEVEL;
                            idx_next          = 2'd0;
                            asm_next          = 32'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIG;
            idx_reg    <= '0;
            asm_reg    <= '0;
            level_reg  <= '0;
            tn_reg     <= '0;
            length_reg <= '0;
            remain_reg <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
            start_reg  <= '0;
            key_reg    <= '0;
            render_reg <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            asm_reg    <= asm_next;
            level_reg  <= level_next;
            tn_reg     <= tn_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            key_reg    <= key_next;
            render_reg <= render_next;
            halted_reg <= halted_next;
        end
    end

    assign stat.halted = halted_reg;
    assign stat.phase  = phase_reg;

endmodule

// ----- design/tnef_out_buf.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnef_out_buf
// two-entry result register with skid slot for the master side
// ---------------------------------------------------------------------------
module tnef_out_buf
    import tnef_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) && out_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
        if (push)
        begin
            if (cnt_next == 2'd0)
                head_next = push_data;
            else
                tail_next = push_data;
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full      = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;

endmodule

// ----- design/tnef_stream_object_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnef_stream_object_parser
// attribute stream parser: signature, key and checksummed attribute records
// ---------------------------------------------------------------------------
// usage
//   s_* carries one stream byte per request in s_tdata, s_tuser marks the end
//   of the stream (byte then ignored). m_* carries one result per finished
//   record, bad signature or end of stream; m_tuser holds the status code.
//   cfg_* writes the signature, attachment level and render name registers;
//   cfg_ready is always high, write only while the parser is idle.
//   throughput: one byte per cycle while the output buffer is not full.
//   a result is registered into the output buffer and shows on m_* once earlier results are taken.
//   a two-entry output buffer lets input continue while m_tready is low;
//   s_tready drops only when both entries hold results.
//   reset clears the parser to the signature phase and empties the buffer;
//   registers return to their defaults. after a bad signature, a checksum
//   mismatch or any end mark the parser drops every byte until reset.
// ---------------------------------------------------------------------------
module tnef_stream_object_parser
    import tnef_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic [0:0]         s_tuser,   // end_of_stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // record_level, record_type, record_name, record_length, data_offset,
    // computed_sum, header_key, render_count
    output logic [DATA_W-1:0]  m_tdata,
    output logic [2:0]         m_tuser,   // status
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    out_res;
    core_stat_t stat;
    logic       buf_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_signature <= SIGNATURE_RST;
            cfg_reg.attachment_level   <= ATT_LEVEL_RST;
            cfg_reg.render_data_name   <= RENDER_NAME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIGNATURE:   cfg_reg.expected_signature <= cfg_data;
                CFG_ATT_LEVEL:   cfg_reg.attachment_level   <= cfg_data[7:0];
                CFG_RENDER_NAME: cfg_reg.render_data_name   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;

    tnef_parse_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .accept        (accept),
        .data_byte     (s_tdata),
        .end_of_stream (s_tuser[0]),
        .res_valid     (res_valid),
        .res           (res),
        .stat          (stat)
    );

    tnef_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {out_res.render_count, out_res.header_key, out_res.computed_sum,
                      out_res.data_offset, out_res.record_length, out_res.record_name,
                      out_res.record_type, out_res.record_level};

    // no result once halted
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stat.halted |-> !res_valid)
        else $error("result produced while halted");

    // bad signature only out of the signature phase
    a_badsig_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_BAD_SIG) |-> (stat.phase == PH_SIG))
        else $error("bad signature outside signature phase");

    // a mismatch halts the parser
    a_mismatch_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_MISMATCH) |=> stat.halted)
        else $error("parser not halted after checksum mismatch");

    // a new result is never lost in the buffer
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> m_tvalid)
        else $error("result dropped");

endmodule
